// File: rtl/core/sorted_lane_occupancy_list_unit_defines.svh
// Assertion macros for the sorted lane occupancy list unit.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SORTED_LANE_OCCUPANCY_LIST_UNIT_DEFINES_SVH
`define SORTED_LANE_OCCUPANCY_LIST_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SLO_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define SLO_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/slo_pkg.sv
// Shared types and constants for the sorted lane occupancy list unit.
// No dependencies; imported by every module of the block but the entry RAM.
package slo_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ID_W     = 16;
    localparam int POS_W    = 16;
    localparam int OCC_W    = 7;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    typedef enum logic [1:0] {
        MODE_INSERT  = 2'd0,
        MODE_REMOVE  = 2'd1,
        MODE_ADVANCE = 2'd2,
        MODE_QUERY   = 2'd3
    } mode_e;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DUP_HEAD  = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_BLOCKED   = 3'd4
    } status_e;

    typedef struct packed {
        logic [1:0]       mode;
        logic [ID_W-1:0]  car_id;
        logic [POS_W-1:0] car_position;
    } req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic             is_free;
        logic [POS_W-1:0] moved_position;
        logic [OCC_W-1:0] occupancy;
    } rsp_t;

    typedef struct packed {
        logic [ID_W-1:0]  vehicle;
        logic [POS_W-1:0] position;
    } entry_t;

    // Scan control from the sequencer to the scan unit
    typedef struct packed {
        logic             clear;
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic [ID_W-1:0]  key_id;
        logic [POS_W-1:0] key_pos;
    } scan_ctl_t;

    // Findings of one pass over the table
    typedef struct packed {
        logic             head_less;
        logic             less_found;
        logic [IDX_W-1:0] last_less;
        logic             id_found;
        logic [IDX_W-1:0] id_idx;
        logic [POS_W-1:0] id_pos;
        logic             succ_valid;
        logic [POS_W-1:0] succ_pos;
        logic             pos_hit;
    } scan_res_t;

endpackage

// File: rtl/core/slo_entry_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No package dependency.
module slo_entry_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/slo_scan.sv
// Scan unit: folds the entries read from the table into search findings.
// Depends on slo_pkg.
module slo_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  slo_pkg::scan_ctl_t ctl,
    input  slo_pkg::entry_t   beat,
    output slo_pkg::scan_res_t res
);
    import slo_pkg::*;

    scan_res_t res_reg, res_next;
    logic      succ_pend_reg, succ_pend_next;

    always_comb
    begin
        res_next       = res_reg;
        succ_pend_next = succ_pend_reg;
        if (ctl.clear)
        begin
            res_next       = '0;
            succ_pend_next = 1'b0;
        end
        else if (ctl.valid)
        begin
            if (ctl.idx == '0)
            begin
                res_next.head_less = (ctl.key_pos < beat.position);
            end
            // entries arrive in ascending order, so the last hit wins
            if (beat.position < ctl.key_pos)
            begin
                res_next.less_found = 1'b1;
                res_next.last_less  = ctl.idx;
            end
            if (beat.position == ctl.key_pos)
            begin
                res_next.pos_hit = 1'b1;
            end
            // capture the entry right behind the first id match
            if (succ_pend_reg)
            begin
                res_next.succ_valid = 1'b1;
                res_next.succ_pos   = beat.position;
                succ_pend_next      = 1'b0;
            end
            if (!res_reg.id_found && (beat.vehicle == ctl.key_id))
            begin
                res_next.id_found = 1'b1;
                res_next.id_idx   = ctl.idx;
                res_next.id_pos   = beat.position;
                succ_pend_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg       <= '0;
            succ_pend_reg <= 1'b0;
        end
        else
        begin
            res_reg       <= res_next;
            succ_pend_reg <= succ_pend_next;
        end
    end

    assign res = res_reg;

endmodule

// File: rtl/core/slo_seq.sv
// Sequencer: scans the entry RAM, decides each request, shifts and writes back.
// Depends on slo_pkg; drives slo_entry_ram and slo_scan.
module slo_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  slo_pkg::req_t      req_data,
    output logic               res_valid,
    output slo_pkg::rsp_t      res_data,
    input  logic               res_take,
    output logic               rd_en,
    output logic [slo_pkg::IDX_W-1:0] rd_addr,
    input  slo_pkg::entry_t    rd_data,
    output logic               wr_en,
    output logic [slo_pkg::IDX_W-1:0] wr_addr,
    output slo_pkg::entry_t    wr_data,
    output slo_pkg::scan_ctl_t scan_ctl,
    input  slo_pkg::scan_res_t scan_res
);
    import slo_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_SCAN    = 8'b0000_0010,
        S_DRAIN   = 8'b0000_0100,
        S_DECIDE  = 8'b0000_1000,
        S_SHIFT   = 8'b0001_0000,
        S_SHDRAIN = 8'b0010_0000,
        S_WRITE   = 8'b0100_0000,
        S_RESULT  = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    req_t             req_reg, req_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [IDX_W-1:0] end_reg, end_next;
    logic [IDX_W-1:0] at_reg, at_next;
    logic             up_reg, up_next;
    entry_t           wr_entry_reg, wr_entry_next;
    status_e          status_reg, status_next;
    logic             free_reg, free_next;
    logic [POS_W-1:0] moved_reg, moved_next;
    logic             rd_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] at_full;
    logic             scan_last;
    logic             insert_place;
    logic             table_full;
    logic [POS_W-1:0] pos_inc;
    logic             shift_wr;

    assign req_ready    = (state_reg == S_IDLE);
    assign rd_en        = (state_reg == S_SCAN) || (state_reg == S_SHIFT);
    assign rd_addr      = ptr_reg;
    assign cnt_m1       = cnt_reg - CNT_W'(1);
    assign scan_last    = (CNT_W'(ptr_reg) == cnt_m1);
    assign insert_place = (cnt_reg == '0) || scan_res.head_less || scan_res.less_found;
    assign table_full   = (cnt_reg >= CNT_W'(CAPACITY));
    assign at_full      = ((cnt_reg == '0) || scan_res.head_less) ? '0
                          : CNT_W'(scan_res.last_less) + CNT_W'(1);
    assign pos_inc      = scan_res.id_pos + POS_W'(1);
    assign shift_wr     = rd_valid_reg && ((state_reg == S_SHIFT) || (state_reg == S_SHDRAIN));

    assign scan_ctl.clear   = req_valid && req_ready;
    assign scan_ctl.valid   = rd_valid_reg && ((state_reg == S_SCAN) || (state_reg == S_DRAIN));
    assign scan_ctl.idx     = rd_idx_reg;
    assign scan_ctl.key_id  = req_reg.car_id;
    assign scan_ctl.key_pos = req_reg.car_position;

    // Write port: shift moves take priority; the final write lands afterwards
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = at_reg;
        wr_data = wr_entry_reg;
        if (shift_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = up_reg ? (rd_idx_reg + IDX_W'(1)) : (rd_idx_reg - IDX_W'(1));
            wr_data = rd_data;
        end
        else if (state_reg == S_WRITE)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        cnt_next      = cnt_reg;
        ptr_next      = ptr_reg;
        end_next      = end_reg;
        at_next       = at_reg;
        up_next       = up_reg;
        wr_entry_next = wr_entry_reg;
        status_next   = status_reg;
        free_next     = free_reg;
        moved_next    = moved_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next    = req_data;
                    ptr_next    = '0;
                    status_next = ST_OK;
                    free_next   = 1'b0;
                    moved_next  = '0;
                    state_next  = (cnt_reg == '0) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    ptr_next = ptr_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_RESULT;
                case (req_reg.mode)
                    MODE_INSERT:
                    begin
                        if (!insert_place)
                        begin
                            status_next = ST_DUP_HEAD;
                        end
                        else if (table_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            at_next       = at_full[IDX_W-1:0];
                            wr_entry_next = '{vehicle: req_reg.car_id,
                                              position: req_reg.car_position};
                            if (at_full < cnt_reg)
                            begin
                                up_next    = 1'b1;
                                ptr_next   = cnt_m1[IDX_W-1:0];
                                end_next   = at_full[IDX_W-1:0];
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                state_next = S_WRITE;
                            end
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (!scan_res.id_found)
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                        else if ((CNT_W'(scan_res.id_idx) + CNT_W'(1)) < cnt_reg)
                        begin
                            up_next    = 1'b0;
                            ptr_next   = scan_res.id_idx + IDX_W'(1);
                            end_next   = cnt_m1[IDX_W-1:0];
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            cnt_next = cnt_m1;
                        end
                    end
                    MODE_ADVANCE:
                    begin
                        if (!scan_res.id_found)
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                        else if ((scan_res.id_pos == POS_MAX) ||
                                 (scan_res.succ_valid && (scan_res.succ_pos == pos_inc)))
                        begin
                            status_next = ST_BLOCKED;
                            moved_next  = scan_res.id_pos;
                        end
                        else
                        begin
                            moved_next    = pos_inc;
                            at_next       = scan_res.id_idx;
                            wr_entry_next = '{vehicle: req_reg.car_id, position: pos_inc};
                            state_next    = S_WRITE;
                        end
                    end
                    MODE_QUERY:
                    begin
                        free_next = !scan_res.pos_hit;
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_SHIFT:
            begin
                if (ptr_reg == end_reg)
                begin
                    state_next = S_SHDRAIN;
                end
                else
                begin
                    ptr_next = up_reg ? (ptr_reg - IDX_W'(1)) : (ptr_reg + IDX_W'(1));
                end
            end
            S_SHDRAIN:
            begin
                if (up_reg)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    cnt_next   = cnt_m1;
                    state_next = S_RESULT;
                end
            end
            S_WRITE:
            begin
                if (req_reg.mode == MODE_INSERT)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        ptr_reg      <= ptr_next;
        end_reg      <= end_next;
        at_reg       <= at_next;
        up_reg       <= up_next;
        wr_entry_reg <= wr_entry_next;
        status_reg   <= status_next;
        free_reg     <= free_next;
        moved_reg    <= moved_next;
        rd_idx_reg   <= rd_addr;
    end

    assign res_valid               = (state_reg == S_RESULT);
    assign res_data.status         = status_reg;
    assign res_data.is_free        = free_reg;
    assign res_data.moved_position = moved_reg;
    assign res_data.occupancy      = OCC_W'(cnt_reg);

endmodule

// File: rtl/core/sorted_lane_occupancy_list_unit.sv
// Sorted lane occupancy list unit: top level with the response register.
// Depends on slo_pkg, slo_entry_ram, slo_scan, slo_seq and the defines header.
//
// Keeps up to CAPACITY vehicles (id, position) in one entry RAM, ordered by
// position from slot 0 (head) to the tail, and answers one request per word:
// insert, remove by id, advance by id, or ask whether a position is free.
// Every request returns exactly one response word carrying a status, the
// free flag, the position after an advance and the occupancy afterwards.
// All requests go through the RAM's single read port: a pass over the n
// live entries (one per cycle), then for insert and remove a shift pass over
// the m entries behind the affected slot (one per cycle), before an insert's write.
// A full output register holds the sequencer in its result state until it drains.
// Responses are held in an output register, so a new request is taken while
// the previous response still waits downstream. No clearing pass is needed:
// only slots below the count are ever read.
`include "sorted_lane_occupancy_list_unit_defines.svh"

module sorted_lane_occupancy_list_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  slo_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output slo_pkg::rsp_t rsp_data
);
    import slo_pkg::*;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    scan_ctl_t        scan_ctl;
    scan_res_t        scan_res;
    logic             res_valid;
    rsp_t             res_data;
    logic             res_take;

    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg;

    // Entry store: vehicle id and position per slot
    slo_entry_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Fold each scanned entry into the search findings
    slo_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scan_ctl),
        .beat  (rd_data),
        .res   (scan_res)
    );

    // Request sequencing: scan, decide, shift, write back
    slo_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_data  (res_data),
        .res_take  (res_take),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .scan_ctl  (scan_ctl),
        .scan_res  (scan_res)
    );

    // Load a finished response whenever the output register is empty or
    // is being drained in this cycle; otherwise hold the sequencer.
    assign res_take = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_valid && res_take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            rsp_reg <= res_data;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // The sequencer leaves idle straight after taking a request
    `SLO_CHECK_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready,
        "sequencer still idle after accepting a request")

    // A response handed over lands unchanged in the output register
    `SLO_CHECK_NEXT(a_result_lands, res_valid && res_take,
        rsp_valid && (rsp_data == $past(res_data)),
        "response lost on its way to the output register")

    // A free flag only ever comes with a clean status and no movement
    `SLO_CHECK_NOW(a_free_is_clean, res_valid && res_data.is_free,
        (res_data.status == ST_OK) && (res_data.moved_position == '0),
        "free flag raised on a response that is not a clean query")

endmodule
